// ===== design/indexed_max_priority_table_defines.svh =====
// Assertion macros shared by the indexed max-priority table RTL.
// No dependencies; included by indexed_max_priority_table.sv, the only file that carries assertions.
`ifndef INDEXED_MAX_PRIORITY_TABLE_DEFINES_SVH
`define INDEXED_MAX_PRIORITY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define IMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define IMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/imt_pkg.sv =====
// Package for the indexed max-priority table: sizes, codes and the
// request/response types between the sequencer and the entry store.
package imt_pkg;

  localparam int ENTRIES    = 64;
  localparam int ORDER_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);

  // Fixed field widths
  localparam int KIND_W  = 2;
  localparam int ID_W    = 6;
  localparam int LEVEL_W = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd127;
  localparam logic [LEVEL_W-1:0] LIMIT_RESET = 7'd100;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

  // Store access request: one read port, one write port
  typedef struct packed {
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic                  lvl_we;
    logic                  ord_we;
    logic                  set_valid;
    logic                  clr_valid;
    logic [LEVEL_W-1:0]    wr_level;
    logic [ORDER_BITS-1:0] wr_order;
  } store_req_t;

  // Registered read data
  typedef struct packed {
    logic                  valid;
    logic [LEVEL_W-1:0]    level;
    logic [ORDER_BITS-1:0] order;
  } store_rsp_t;

endpackage

// ===== design/imt_if.sv =====
// Channel interfaces for the indexed max-priority table.
// Depends on imt_pkg for the field widths.
interface imt_item_if;
  import imt_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   entry_id;
  logic [LEVEL_W-1:0] amount;
  modport source (output valid, kind, entry_id, amount, input ready);
  modport sink   (input valid, kind, entry_id, amount, output ready);
endinterface

interface imt_result_if;
  import imt_pkg::*;
  logic            valid;
  logic            ready;
  logic            found;
  logic [ID_W-1:0] chosen_id;
  modport source (output valid, found, chosen_id, input ready);
  modport sink   (input valid, found, chosen_id, output ready);
endinterface

// ===== design/imt_store.sv =====
// Entry store: level/arrival memory with registered read, plus valid flops.
// Depends on imt_pkg.
module imt_store (
  input  logic                clk,
  input  logic                rst,
  input  imt_pkg::store_req_t req,
  output imt_pkg::store_rsp_t rsp
);
  import imt_pkg::*;

  logic [LEVEL_W-1:0]    level_mem [ENTRIES];
  logic [ORDER_BITS-1:0] order_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid;

  // Memory write and registered read; the valid bit is read alongside
  always_ff @(posedge clk) begin
    if (req.lvl_we) begin
      level_mem[req.wr_addr] <= req.wr_level;
    end
    if (req.ord_we) begin
      order_mem[req.wr_addr] <= req.wr_order;
    end
    rsp.level <= level_mem[req.rd_addr];
    rsp.order <= order_mem[req.rd_addr];
    rsp.valid <= valid[req.rd_addr];
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (req.set_valid) begin
        valid[req.wr_addr] <= 1'b1;
      end else if (req.clr_valid) begin
        valid[req.wr_addr] <= 1'b0;
      end
    end
  end

endmodule

// ===== design/imt_best.sv =====
// Compare unit: keeps the best live candidate seen during a scan.
// Depends on imt_pkg.
module imt_best (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        cand_en,
  input  logic [imt_pkg::IDX_W-1:0]   cand_id,
  input  imt_pkg::store_rsp_t         cand,
  input  logic [imt_pkg::LEVEL_W-1:0] limit,
  output logic                        have,
  output logic [imt_pkg::IDX_W-1:0]   best_id
);
  import imt_pkg::*;

  logic [LEVEL_W-1:0]    best_level;
  logic [ORDER_BITS-1:0] best_order;
  logic                  live;
  logic                  better;

  // Higher level wins; equal level goes to the earlier arrival.
  // Scan runs in ascending id, so a full tie keeps the lower id.
  assign live   = cand.valid && (cand.level <= limit);
  assign better = !have || (cand.level > best_level) ||
                  ((cand.level == best_level) && (cand.order < best_order));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (clear) begin
      have <= 1'b0;
    end else if (cand_en && live && better) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_en && live && better) begin
      best_id    <= cand_id;
      best_level <= cand.level;
      best_order <= cand.order;
    end
  end

endmodule

// ===== design/indexed_max_priority_table.sv =====
// Indexed max-priority table. Insert and remove complete in the transfer
// cycle; an add reads the memory, then makes a saturating write. A query
// walks all ENTRIES (64) entries through the single memory read port, one per
// cycle, and its result is registered once the last candidate has been
// compared and the result channel has taken any previous result. The block
// takes no new item while an add or query is in progress. Valid bits live in
// flip-flops cleared by reset, so no clearing pass follows reset.
`include "indexed_max_priority_table_defines.svh"

module indexed_max_priority_table (
  input  logic                        clk,
  input  logic                        rst,
  imt_item_if.sink                    item,
  imt_result_if.source                result,
  input  logic                        cfg_wr_en,
  input  logic [imt_pkg::LEVEL_W-1:0] cfg_wr_data
);
  import imt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ADD   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_REPLY = 2'd3;

  logic [1:0]            state;
  logic [IDX_W-1:0]      scan_idx;
  logic                  cand_en;
  logic [IDX_W-1:0]      cand_id;
  logic [LEVEL_W-1:0]    live_limit;
  logic [ORDER_BITS-1:0] arrival;
  logic [IDX_W-1:0]      op_id;
  logic [LEVEL_W-1:0]    op_amount;
  logic                  out_valid;
  logic                  out_found;
  logic [ID_W-1:0]       out_id;

  logic                  xfer;
  logic                  id_ok;
  logic [IDX_W-1:0]      item_idx;
  logic [LEVEL_W:0]      add_sum;
  logic [LEVEL_W-1:0]    add_sat;
  logic                  out_free;
  logic                  reply_go;
  logic                  have;
  logic [IDX_W-1:0]      best_id;
  store_req_t            req;
  store_rsp_t            rsp;

  assign item.ready = (state == ST_IDLE);
  assign xfer       = item.valid && item.ready;
  assign id_ok      = (32'(item.entry_id) < 32'(ENTRIES));
  assign item_idx   = IDX_W'(item.entry_id);
  assign out_free   = !out_valid || result.ready;
  // Reply once the last candidate has been compared and the output is free
  assign reply_go   = (state == ST_REPLY) && !cand_en && out_free;

  // Saturating add on the stored level
  assign add_sum = {1'b0, rsp.level} + {1'b0, op_amount};
  assign add_sat = add_sum[LEVEL_W] ? LEVEL_MAX : add_sum[LEVEL_W-1:0];

  // Store access
  always_comb begin
    req           = '0;
    req.rd_addr   = (state == ST_SCAN) ? scan_idx : item_idx;
    req.wr_addr   = (state == ST_ADD) ? op_id : item_idx;
    req.wr_level  = (state == ST_ADD) ? add_sat : item.amount;
    req.wr_order  = arrival;
    if (state == ST_ADD) begin
      req.lvl_we = rsp.valid;
    end else if (xfer && id_ok) begin
      case (item.kind)
        KIND_INSERT: begin
          req.lvl_we    = 1'b1;
          req.ord_we    = 1'b1;
          req.set_valid = 1'b1;
        end
        KIND_REMOVE: req.clr_valid = 1'b1;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cand_en <= 1'b0;
    end else begin
      cand_en <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (xfer && item.kind == KIND_QUERY) begin
            state <= ST_SCAN;
          end else if (xfer && item.kind == KIND_ADD && id_ok) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: state <= ST_IDLE;
        ST_SCAN: begin
          if (scan_idx == IDX_W'(ENTRIES - 1)) begin
            state <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          // last candidate is compared in the first reply cycle; then wait for a free output
          if (reply_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scan address, candidate tag and latched operands
  always_ff @(posedge clk) begin
    cand_id <= scan_idx;
    if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end else begin
      scan_idx <= '0;
    end
    if (xfer) begin
      op_id     <= item_idx;
      op_amount <= item.amount;
    end
  end

  // Limit register and arrival counter
  always_ff @(posedge clk) begin
    if (rst) begin
      live_limit <= LIMIT_RESET;
      arrival    <= ORDER_BITS'(1);
    end else begin
      if (cfg_wr_en) begin
        live_limit <= cfg_wr_data;
      end
      if (xfer && id_ok && item.kind == KIND_INSERT) begin
        arrival <= arrival + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (reply_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_go) begin
      out_found <= have;
      out_id    <= have ? ID_W'(best_id) : '0;
    end
  end

  assign result.valid     = out_valid;
  assign result.found     = out_found;
  assign result.chosen_id = out_id;

  imt_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  imt_best u_best (
    .clk     (clk),
    .rst     (rst),
    .clear   (xfer),
    .cand_en (cand_en),
    .cand_id (cand_id),
    .cand    (rsp),
    .limit   (live_limit),
    .have    (have),
    .best_id (best_id)
  );

  // Checks
  `IMT_ASSERT_NEXT(a_query_starts_scan, clk, rst, xfer && item.kind == KIND_QUERY, state == ST_SCAN && scan_idx == '0, "query did not start a scan at entry zero")
  `IMT_ASSERT_SAME(a_scan_no_write, clk, rst, state == ST_SCAN, !req.lvl_we && !req.ord_we && !req.set_valid && !req.clr_valid, "store written during a scan")
  `IMT_ASSERT_SAME(a_result_from_reply, clk, rst, $rose(out_valid), $past(state) == ST_REPLY, "result raised outside reply")
  `IMT_ASSERT_SAME(a_empty_zero_id, clk, rst, out_valid && !out_found, out_id == '0, "nonzero id with nothing found")

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for indexed_max_priority_table: directed rows, some
// with typed expected replies, the rest checked against an in-bench table predictor.
// Depends on imt_pkg, imt_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import imt_pkg::*;

  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int CHUNK_ITEMS   = 125;
  localparam int NUM_ROWS      = 25;
  localparam longint WATCHDOG_NS = 64'd10_000_000;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] chosen_id;
  } reply_t;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_op_e;

  typedef struct packed {
    row_op_e            op;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    entry_id;
    logic [LEVEL_W-1:0] amount;     // new limit on ROW_LIMIT rows
    logic               typed;
    logic               want_found;
    logic [ID_W-1:0]    want_id;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [LEVEL_W-1:0] cfg_wr_data;

  imt_item_if   item_ch();
  imt_result_if result_ch();

  indexed_max_priority_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Predictor copy of the table
  logic                  tbl_valid   [ENTRIES];
  logic [LEVEL_W-1:0]    tbl_level   [ENTRIES];
  logic [ORDER_BITS-1:0] tbl_order   [ENTRIES];
  logic [ORDER_BITS-1:0] next_arrival;
  logic [LEVEL_W-1:0]    live_limit;

  reply_t pending_replies[$];
  reply_t want_reply;

  int src_gap_pct;
  int snk_stall_pct;
  int mismatches;
  int items_sent;
  int queries_sent;
  int replies_checked;
  int limit_writes;

  // Best live entry: highest level, then earliest arrival, then lowest id
  function automatic reply_t predict_top();
    reply_t                best;
    logic [LEVEL_W-1:0]    best_lvl;
    logic [ORDER_BITS-1:0] best_ord;
    best     = '0;
    best_lvl = '0;
    best_ord = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_level[i] <= live_limit) begin
        if (!best.found || tbl_level[i] > best_lvl ||
            (tbl_level[i] == best_lvl && tbl_order[i] < best_ord)) begin
          best.found     = 1'b1;
          best.chosen_id = ID_W'(i);
          best_lvl       = tbl_level[i];
          best_ord       = tbl_order[i];
        end
      end
    end
    return best;
  endfunction

  function automatic void update_table(input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] id,
                                       input logic [LEVEL_W-1:0] amt);
    logic [LEVEL_W:0] sum;
    case (kind)
      KIND_INSERT: begin
        tbl_valid[id]   = 1'b1;
        tbl_level[id]   = amt;
        tbl_order[id]   = next_arrival;
        next_arrival    = next_arrival + 1'b1;
      end
      KIND_ADD: begin
        if (tbl_valid[id]) begin
          sum = {1'b0, tbl_level[id]} + {1'b0, amt};
          tbl_level[id] = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];
        end
      end
      KIND_REMOVE: tbl_valid[id] = 1'b0;
      default: ;
    endcase
  endfunction

  // Present one item, hold it until the transfer, then predict its effect
  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                           input logic [LEVEL_W-1:0] amt, input logic typed,
                           input reply_t want);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.kind     <= kind;
    item_ch.entry_id <= id;
    item_ch.amount   <= amt;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
    if (kind == KIND_QUERY) begin
      queries_sent++;
      pending_replies.push_back(typed ? want : predict_top());
    end else begin
      update_table(kind, id, amt);
    end
  endtask

  // Limit writes only with the block idle: no reply owed and any update settled
  task automatic set_limit(input logic [LEVEL_W-1:0] value);
    item_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    live_limit  = value;
    limit_writes++;
  endtask

  // Mostly well-formed traffic on a small id pool, some noise over the full range
  task automatic run_random(input int count);
    int                 sel;
    int                 lo;
    int                 hi;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] amt;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      id  = ($urandom_range(0, 9) < 8) ? ID_W'($urandom_range(0, 11))
                                       : ID_W'($urandom_range(0, 63));
      lo  = (live_limit > 2) ? live_limit - 2 : 0;
      hi  = (live_limit < 125) ? live_limit + 2 : 127;
      if (sel < 5) begin
        kind = KIND_W'($urandom_range(0, 3));
        id   = ID_W'($urandom_range(0, 63));
        amt  = LEVEL_W'($urandom_range(0, 127));
      end else if (sel < 35) begin
        kind = KIND_INSERT;
        sel  = $urandom_range(0, 9);
        if (sel < 5)      amt = LEVEL_W'($urandom_range(lo, hi));
        else if (sel < 8) amt = LEVEL_W'($urandom_range(0, 127));
        else              amt = $urandom_range(0, 1) ? LEVEL_MAX : '0;
      end else if (sel < 55) begin
        kind = KIND_ADD;
        sel  = $urandom_range(0, 9);
        if (sel < 7)      amt = LEVEL_W'($urandom_range(0, 4));
        else if (sel < 9) amt = LEVEL_W'($urandom_range(0, 127));
        else              amt = LEVEL_MAX;
      end else if (sel < 67) begin
        kind = KIND_REMOVE;
        amt  = LEVEL_W'($urandom_range(0, 127));
      end else begin
        kind = KIND_QUERY;
        amt  = LEVEL_W'($urandom_range(0, 127));
      end
      push_item(kind, id, amt, 1'b0, '0);
    end
  endtask

  // Result side: random hold-off and in-order compare
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: found=%0d chosen_id=%0d",
               result_ch.found, result_ch.chosen_id);
        mismatches++;
      end else begin
        want_reply = pending_replies.pop_front();
        replies_checked++;
        if (result_ch.found !== want_reply.found) begin
          $error("found: expected %0d, got %0d", want_reply.found, result_ch.found);
          mismatches++;
        end
        if (result_ch.chosen_id !== want_reply.chosen_id) begin
          $error("chosen_id: expected %0d, got %0d",
                 want_reply.chosen_id, result_ch.chosen_id);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_NS);
    $error("timeout with %0d replies outstanding", pending_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    row_t plan [NUM_ROWS];

    rst              = 1'b1;
    item_ch.valid    = 1'b0;
    item_ch.kind     = KIND_INSERT;
    item_ch.entry_id = '0;
    item_ch.amount   = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    src_gap_pct      = 14;
    snk_stall_pct    = 59;
    mismatches       = 0;
    items_sent       = 0;
    queries_sent     = 0;
    replies_checked  = 0;
    limit_writes     = 0;
    live_limit       = LIMIT_RESET;
    next_arrival     = 1;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_level[i]   = '0;
      tbl_order[i]   = '0;
    end

    // Directed rows; typed expectations only where obvious
    plan = '{
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b1, 1'b0, 6'd0},  // empty after reset
      '{ROW_ITEM,  KIND_INSERT, 6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b1, 1'b1, 6'd0},
      '{ROW_ITEM,  KIND_INSERT, 6'd63, 7'd100, 1'b0, 1'b0, 6'd0},  // right at the limit
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b1, 1'b1, 6'd63},
      '{ROW_ITEM,  KIND_INSERT, 6'd5,  7'd101, 1'b0, 1'b0, 6'd0},  // valid, not live
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_ADD,    6'd63, 7'd1,   1'b0, 1'b0, 6'd0},  // pushed past limit
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_INSERT, 6'd10, 7'd0,   1'b0, 1'b0, 6'd0},  // level tie, later
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_INSERT, 6'd0,  7'd0,   1'b0, 1'b0, 6'd0},  // reinsert restamps
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_ADD,    6'd10, 7'd90,  1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_ADD,    6'd10, 7'd127, 1'b0, 1'b0, 6'd0},  // saturates
      '{ROW_LIMIT, KIND_QUERY,  6'd0,  7'd127, 1'b0, 1'b0, 6'd0},  // every valid is live
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_REMOVE, 6'd10, 7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_ADD,    6'd10, 7'd5,   1'b0, 1'b0, 6'd0},  // retired: ignored
      '{ROW_ITEM,  KIND_REMOVE, 6'd10, 7'd0,   1'b0, 1'b0, 6'd0},  // retired: ignored
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_LIMIT, KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_REMOVE, 6'd0,  7'd0,   1'b0, 1'b0, 6'd0},
      '{ROW_ITEM,  KIND_QUERY,  6'd0,  7'd0,   1'b0, 1'b0, 6'd0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (plan[r].op == ROW_LIMIT)
        set_limit(plan[r].amount);
      else
        push_item(plan[r].kind, plan[r].entry_id, plan[r].amount, plan[r].typed,
                  '{plan[r].want_found, plan[r].want_id});
    end

    // Random chunks; idle pattern switches every two chunks
    for (int c = 0; c < 6; c++) begin
      case (c)
        0: set_limit(LEVEL_MAX);
        1: set_limit(LEVEL_W'($urandom_range(0, 127)));
        2: begin
          src_gap_pct   = 59;
          snk_stall_pct = 14;
          set_limit('0);
        end
        3: set_limit(7'd126);
        4: begin
          src_gap_pct   = 0;
          snk_stall_pct = 0;
          set_limit(LIMIT_RESET);
        end
        default: set_limit(LEVEL_W'($urandom_range(0, 127)));
      endcase
      run_random(CHUNK_ITEMS);
    end

    item_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d items sent, %0d queries, %0d replies checked",
             items_sent, queries_sent, replies_checked);
    $display("tb: %0d limit writes across three idle patterns, %0d mismatches",
             limit_writes, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== indexed_max_priority_table.f =====
+incdir+design
design/imt_pkg.sv
design/imt_if.sv
design/imt_store.sv
design/imt_best.sv
design/indexed_max_priority_table.sv
sim/tb.sv
